### src/ocw_pkg.sv
// shared constants, types and the arctangent table for the omni wheel speed pipeline
// no dependencies; compiled first

package ocw_pkg;

  // field widths
  localparam int TS_W  = 14;  // travel speed
  localparam int TD_W  = 15;  // travel direction
  localparam int TR_W  = 16;  // turn rate
  localparam int RAD_W = 10;  // chassis radius register
  localparam int WS_W  = 16;  // wheel speed
  localparam int WHEELS = 4;

  // parameter defaults
  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 12;
  localparam int ATAN_LEN            = 24;

  localparam logic [RAD_W-1:0] RADIUS_RST = 10'd300;

  // fixed point constants, angles in q30 radians
  localparam logic signed [31:0] GAIN_Q30      = 32'sd652032874;
  localparam logic [29:0]        INV_SQRT2_Q30 = 30'd759250125;
  localparam logic signed [34:0] PI_Q30        = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30   = 35'sd1686629713;
  localparam logic signed [34:0] TWO_PI_Q30    = 35'sd6746518852;

  // 2^20 / (2 pi), used to estimate whole turns of the direction
  localparam logic signed [18:0] TURN_RECIP    = 19'sd166886;
  localparam int                 TURN_RECIP_SH = 20;
  localparam int                 KP_W          = TD_W + 19;
  localparam int                 K_W           = 6;

  // datapath widths
  localparam int XW      = 46;  // cordic x and y, q30 mm/s
  localparam int ZC_W    = 34;  // cordic angle
  localparam int RW_W    = 27;  // radius times turn rate
  localparam int RW_SH   = 18;  // radius times turn rate to q30
  localparam int SW      = 48;  // wheel sum
  localparam int MAG_LSB = 15;
  localparam int MAG_W   = 32;
  localparam int PROD_W  = MAG_W + 30;
  localparam int Q_LSB   = 45;
  localparam int Q_W     = 17;

  localparam logic [Q_W-1:0]         SAT_NEG_MAG = 17'd32768;
  localparam logic [Q_W-1:0]         SAT_POS_MAG = 17'd32767;
  localparam logic signed [WS_W-1:0] WS_MIN      = 16'sh8000;
  localparam logic signed [WS_W-1:0] WS_MAX      = 16'sh7fff;

  // word carried through the cordic stages
  typedef struct packed {
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [ZC_W-1:0] z;
    logic                   flip;
    logic signed [RW_W-1:0] rw;
  } cordic_t;

  // atan(2^-i) in q30
  function automatic logic signed [ZC_W-1:0] atan_q30(input logic [4:0] idx);
    case (idx)
      5'd0:    atan_q30 = ZC_W'(32'h3243_F6A8);
      5'd1:    atan_q30 = ZC_W'(32'h1DAC_6705);
      5'd2:    atan_q30 = ZC_W'(32'h0FAD_BAFC);
      5'd3:    atan_q30 = ZC_W'(32'h07F5_6EA6);
      5'd4:    atan_q30 = ZC_W'(32'h03FE_AB76);
      5'd5:    atan_q30 = ZC_W'(32'h01FF_D55B);
      5'd6:    atan_q30 = ZC_W'(32'h00FF_FAAA);
      5'd7:    atan_q30 = ZC_W'(32'h007F_FF55);
      5'd8:    atan_q30 = ZC_W'(32'h003F_FFEA);
      5'd9:    atan_q30 = ZC_W'(32'h001F_FFFD);
      5'd10:   atan_q30 = ZC_W'(32'h000F_FFFF);
      5'd11:   atan_q30 = ZC_W'(32'h0007_FFFF);
      5'd12:   atan_q30 = ZC_W'(32'h0003_FFFF);
      5'd13:   atan_q30 = ZC_W'(32'h0001_FFFF);
      5'd14:   atan_q30 = ZC_W'(32'h0000_FFFF);
      5'd15:   atan_q30 = ZC_W'(32'h0000_7FFF);
      5'd16:   atan_q30 = ZC_W'(32'h0000_3FFF);
      5'd17:   atan_q30 = ZC_W'(32'h0000_1FFF);
      5'd18:   atan_q30 = ZC_W'(32'h0000_0FFF);
      5'd19:   atan_q30 = ZC_W'(32'h0000_07FF);
      5'd20:   atan_q30 = ZC_W'(32'h0000_03FF);
      5'd21:   atan_q30 = ZC_W'(32'h0000_01FF);
      5'd22:   atan_q30 = ZC_W'(32'h0000_00FF);
      5'd23:   atan_q30 = ZC_W'(32'h0000_007F);
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage

### src/ocw_if.sv
// valid/ready channel interfaces: command in, wheel speeds out, radius write
// depends on ocw_pkg for the field widths

interface ocw_cmd_if;
  import ocw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [TS_W-1:0] travel_speed;
  logic signed [TD_W-1:0] travel_direction;
  logic signed [TR_W-1:0] turn_rate;
  modport source (output valid, travel_speed, travel_direction, turn_rate, input ready);
  modport sink (input valid, travel_speed, travel_direction, turn_rate, output ready);
endinterface

interface ocw_wheel_if;
  import ocw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [WS_W-1:0] wheel_one_speed;
  logic signed [WS_W-1:0] wheel_two_speed;
  logic signed [WS_W-1:0] wheel_three_speed;
  logic signed [WS_W-1:0] wheel_four_speed;
  modport source (output valid, wheel_one_speed, wheel_two_speed, wheel_three_speed,
                  wheel_four_speed, input ready);
  modport sink (input valid, wheel_one_speed, wheel_two_speed, wheel_three_speed,
                wheel_four_speed, output ready);
endinterface

interface ocw_cfg_if;
  import ocw_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAD_W-1:0] chassis_radius;
  modport source (output valid, chassis_radius, input ready);
  modport sink (input valid, chassis_radius, output ready);
endinterface

### src/ocw_cordic_stage.sv
// one registered rotation step of the cordic pipeline
// depends on ocw_pkg (cordic_t, atan_q30)

module ocw_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            load,
  input  ocw_pkg::cordic_t d_in,
  output ocw_pkg::cordic_t d_out
);
  import ocw_pkg::*;

  localparam logic [4:0] ATAN_IDX = 5'(STAGE);

  cordic_t              stage_r;
  cordic_t              stage_nxt;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  // rotate towards zero residual angle
  always_comb begin
    dx        = d_in.y >>> STAGE;
    dy        = d_in.x >>> STAGE;
    stage_nxt = d_in;
    if (!d_in.z[ZC_W-1]) begin
      stage_nxt.x = d_in.x - dx;
      stage_nxt.y = d_in.y + dy;
      stage_nxt.z = d_in.z - atan_q30(ATAN_IDX);
    end else begin
      stage_nxt.x = d_in.x + dx;
      stage_nxt.y = d_in.y - dy;
      stage_nxt.z = d_in.z + atan_q30(ATAN_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r <= stage_nxt;
    end
  end

  assign d_out = stage_r;

endmodule

### src/omni_chassis_wheel_speeds.sv
// X-drive omni chassis wheel speeds from speed, direction and turn rate
// From an accepted command word to its wheel word, four stages reduce the direction
// and scale the speed, one stage per cordic rotation (16 by default), and five stages
// form, scale and saturate the four wheel sums. A new command word is taken every
// cycle while the first stage can move; each stage holds one word and the ready chain
// lets a stage fill whenever the one after it is empty or moving, so a held output
// word stalls only the stages that are full behind it.
// The chassis radius register is always ready; the turn term reads it as a command
// word moves from stage 1 into stage 2, so write it only while no command word is in
// flight. Wheel speeds are truncated toward zero and saturated to 16 bits.
// depends on ocw_pkg, ocw_if and ocw_cordic_stage

module omni_chassis_wheel_speeds #(
  parameter int CORDIC_STAGES   = ocw_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = ocw_pkg::ANGLE_FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ocw_cmd_if.sink    in_if,
  ocw_wheel_if.source out_if,
  ocw_cfg_if.sink    cfg_if
);
  import ocw_pkg::*;

  localparam int PRE_N  = 4;
  localparam int POST_N = 5;
  localparam int NSTG   = PRE_N + CORDIC_STAGES + POST_N;
  localparam int LAST   = NSTG - 1;
  localparam int P1     = PRE_N + CORDIC_STAGES;
  localparam int P2     = P1 + 1;
  localparam int P3     = P1 + 2;
  localparam int P4     = P1 + 3;

  localparam int ZSH    = 30 - ANGLE_FRAC_BITS;
  localparam int ZIN_W  = TD_W + ZSH;
  localparam int ZW     = ((ZIN_W > 34) ? ZIN_W : 34) + 2;
  localparam int KSH    = ANGLE_FRAC_BITS + TURN_RECIP_SH;
  localparam int DE_W   = XW + 1;

  localparam logic signed [ZW-1:0] PI_Z      = ZW'(PI_Q30);
  localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(HALF_PI_Q30);
  localparam logic signed [ZW-1:0] TWO_PI_Z  = ZW'(TWO_PI_Q30);

  // radius register
  logic [RAD_W-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_if.valid) begin
      radius_r <= cfg_if.chassis_radius;
    end
  end

  assign cfg_if.ready = 1'b1;

  // valid bits and the ready chain
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  wire  [NSTG-1:0] adv;

  assign adv[LAST] = !vld_r[LAST] || out_if.ready;
  for (genvar g = 0; g < LAST; g++) begin : g_adv
    assign adv[g] = !vld_r[g] || adv[g+1];
  end

  assign vld_nxt = (adv & {vld_r[NSTG-2:0], in_if.valid}) | (~adv & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_if.ready = adv[0];

  // stage 0: capture, scale speed by the cordic gain, estimate whole turns
  logic signed [TD_W-1:0] th0_r;
  logic signed [TR_W-1:0] w0_r;
  logic signed [XW-1:0]   x0_r;
  logic signed [KP_W-1:0] kprod0_r;
  logic signed [XW-1:0]   x0_nxt;
  logic signed [KP_W-1:0] kprod0_nxt;

  assign x0_nxt     = XW'(in_if.travel_speed * GAIN_Q30);
  assign kprod0_nxt = KP_W'(in_if.travel_direction * TURN_RECIP);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      th0_r    <= in_if.travel_direction;
      w0_r     <= in_if.turn_rate;
      x0_r     <= x0_nxt;
      kprod0_r <= kprod0_nxt;
    end
  end

  // stage 1: take off the estimated turns, lands in about [0, 2pi)
  logic signed [K_W-1:0]  k_est;
  logic signed [ZW-1:0]   z_in;
  logic signed [ZW-1:0]   z_turns;
  logic signed [ZW-1:0]   z1_nxt;
  logic signed [ZW-1:0]   z1_r;
  logic signed [XW-1:0]   x1_r;
  logic signed [TR_W-1:0] w1_r;
  logic                   thneg1_r;

  assign k_est   = K_W'(kprod0_r >>> KSH);
  assign z_in    = ZW'(th0_r) <<< ZSH;
  assign z_turns = ZW'(k_est * TWO_PI_Z);
  assign z1_nxt  = z_in - z_turns;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      z1_r     <= z1_nxt;
      x1_r     <= x0_r;
      w1_r     <= w0_r;
      thneg1_r <= th0_r[TD_W-1];
    end
  end

  // stage 2: last turn into [-pi, pi], odd multiples of pi keep the input's sign
  logic                   wrap1;
  logic signed [ZW-1:0]   z2_nxt;
  logic signed [ZW-1:0]   z2_r;
  logic signed [XW-1:0]   x2_r;
  logic signed [RW_W-1:0] rw2_nxt;
  logic signed [RW_W-1:0] rw2_r;

  assign wrap1   = thneg1_r ? (z1_r >= PI_Z) : (z1_r > PI_Z);
  assign z2_nxt  = wrap1 ? (z1_r - TWO_PI_Z) : z1_r;
  assign rw2_nxt = RW_W'($signed({1'b0, radius_r}) * w1_r);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      z2_r  <= z2_nxt;
      x2_r  <= x1_r;
      rw2_r <= rw2_nxt;
    end
  end

  // stage 3: fold into [-pi/2, pi/2] and remember to negate the result
  cordic_t c_in_nxt;
  cordic_t c_in_r;

  always_comb begin
    c_in_nxt.x    = x2_r;
    c_in_nxt.y    = '0;
    c_in_nxt.rw   = rw2_r;
    c_in_nxt.flip = 1'b0;
    c_in_nxt.z    = ZC_W'(z2_r);
    if (z2_r > HALF_PI_Z) begin
      c_in_nxt.z    = ZC_W'(z2_r - PI_Z);
      c_in_nxt.flip = 1'b1;
    end else if (z2_r < -HALF_PI_Z) begin
      c_in_nxt.z    = ZC_W'(z2_r + PI_Z);
      c_in_nxt.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      c_in_r <= c_in_nxt;
    end
  end

  // cordic rotation stages
  cordic_t cord [CORDIC_STAGES+1];

  assign cord[0] = c_in_r;

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
    ocw_cordic_stage #(
      .STAGE (s)
    ) u_stage (
      .clk   (clk),
      .load  (adv[PRE_N+s]),
      .d_in  (cord[s]),
      .d_out (cord[s+1])
    );
  end

  // post 1: apply the fold, form y-x and x+y
  cordic_t                c_out;
  logic signed [DE_W-1:0] xe;
  logic signed [DE_W-1:0] ye;
  logic signed [DE_W-1:0] d_nxt;
  logic signed [DE_W-1:0] e_nxt;
  logic signed [DE_W-1:0] d_r;
  logic signed [DE_W-1:0] e_r;
  logic signed [RW_W-1:0] rw_p1_r;

  assign c_out = cord[CORDIC_STAGES];
  assign xe    = DE_W'(c_out.x);
  assign ye    = DE_W'(c_out.y);
  assign d_nxt = c_out.flip ? (xe - ye) : (ye - xe);
  assign e_nxt = c_out.flip ? (-xe - ye) : (xe + ye);

  always_ff @(posedge clk) begin
    if (adv[P1]) begin
      d_r     <= d_nxt;
      e_r     <= e_nxt;
      rw_p1_r <= c_out.rw;
    end
  end

  // post 2: the four wheel sums in q30
  logic signed [SW-1:0] rw_s;
  logic signed [SW-1:0] s_nxt [WHEELS];
  logic signed [SW-1:0] s_r   [WHEELS];

  always_comb begin
    rw_s     = SW'(rw_p1_r) <<< RW_SH;
    s_nxt[0] = rw_s + SW'(d_r);
    s_nxt[1] = rw_s - SW'(e_r);
    s_nxt[2] = rw_s - SW'(d_r);
    s_nxt[3] = rw_s + SW'(e_r);
  end

  always_ff @(posedge clk) begin
    if (adv[P2]) begin
      s_r <= s_nxt;
    end
  end

  // post 3: magnitude truncated to q15, sign kept aside
  logic [SW-1:0]    abs_s   [WHEELS];
  logic [MAG_W-1:0] mag_nxt [WHEELS];
  logic [MAG_W-1:0] mag_r   [WHEELS];
  logic [WHEELS-1:0] neg3_nxt;
  logic [WHEELS-1:0] neg3_r;

  always_comb begin
    for (int k = 0; k < WHEELS; k++) begin
      neg3_nxt[k] = s_r[k][SW-1];
      abs_s[k]    = s_r[k][SW-1] ? SW'(-s_r[k]) : SW'(s_r[k]);
      mag_nxt[k]  = abs_s[k][MAG_LSB +: MAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[P3]) begin
      mag_r  <= mag_nxt;
      neg3_r <= neg3_nxt;
    end
  end

  // post 4: scale by 1/sqrt(2), truncate to an integer
  logic [PROD_W-1:0] prod   [WHEELS];
  logic [Q_W-1:0]    q_nxt  [WHEELS];
  logic [Q_W-1:0]    q_r    [WHEELS];
  logic [WHEELS-1:0] neg4_r;

  always_comb begin
    for (int k = 0; k < WHEELS; k++) begin
      prod[k]  = PROD_W'(mag_r[k] * INV_SQRT2_Q30);
      q_nxt[k] = prod[k][Q_LSB +: Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[P4]) begin
      q_r    <= q_nxt;
      neg4_r <= neg3_r;
    end
  end

  // post 5: sign back on, saturate, output register
  logic signed [WS_W-1:0] ws_nxt [WHEELS];
  logic signed [WS_W-1:0] ws_r   [WHEELS];

  always_comb begin
    for (int k = 0; k < WHEELS; k++) begin
      if (neg4_r[k]) begin
        ws_nxt[k] = (q_r[k] > SAT_NEG_MAG) ? WS_MIN : WS_W'(-q_r[k]);
      end else begin
        ws_nxt[k] = (q_r[k] > SAT_POS_MAG) ? WS_MAX : WS_W'(q_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      ws_r <= ws_nxt;
    end
  end

  assign out_if.valid             = vld_r[LAST];
  assign out_if.wheel_one_speed   = ws_r[0];
  assign out_if.wheel_two_speed   = ws_r[1];
  assign out_if.wheel_three_speed = ws_r[2];
  assign out_if.wheel_four_speed  = ws_r[3];

endmodule

### src/ocw_checker.sv
// port-level checks for omni_chassis_wheel_speeds, attached by bind
// depends on ocw_pkg and the top level's interface ports

module ocw_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [ocw_pkg::WS_W-1:0] wheel_one_speed,
  input logic signed [ocw_pkg::WS_W-1:0] wheel_two_speed,
  input logic signed [ocw_pkg::WS_W-1:0] wheel_three_speed,
  input logic signed [ocw_pkg::WS_W-1:0] wheel_four_speed
);

  // a held wheel word stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("wheel word withdrawn while stalled");

  // a held wheel word keeps its value
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(wheel_one_speed) && $stable(wheel_two_speed)
      && $stable(wheel_three_speed) && $stable(wheel_four_speed))
    else $error("wheel word changed while stalled");

  // a free output stage lets the whole pipeline move
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("command not taken although the pipeline can move");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("wheel word offered straight after reset");

endmodule

bind omni_chassis_wheel_speeds ocw_checker u_ocw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .wheel_one_speed   (out_if.wheel_one_speed),
  .wheel_two_speed   (out_if.wheel_two_speed),
  .wheel_three_speed (out_if.wheel_three_speed),
  .wheel_four_speed  (out_if.wheel_four_speed)
);
